// ----- rtl/core/waypoint_decimate_and_follow_core_macros.svh -----
// Assertion macros shared by the waypoint follower RTL.
`ifndef WAYPOINT_DECIMATE_AND_FOLLOW_CORE_MACROS_SVH
`define WAYPOINT_DECIMATE_AND_FOLLOW_CORE_MACROS_SVH

`ifndef SYNTH

`define WDF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define WDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define WDF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`define WDF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/wdf_pkg.sv -----
// Shared constants for the distance-decimated waypoint follower.
package wdf_pkg;

    localparam int DEF_MAX_WAYPOINTS = 1024;
    localparam int DEF_COORD_BITS    = 24;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL = 1'b1;
    localparam logic [CFG_W-1:0] RST_SPACING = 16'd2000;
    localparam logic [CFG_W-1:0] RST_ARRIVAL = 16'd600;

    // Item kinds
    localparam logic MODE_POSE = 1'b0;
    localparam logic MODE_PATH = 1'b1;

    // Distance arithmetic: differences of up to 32-bit coordinates,
    // magnitudes clamped to 65536 before squaring.
    localparam int DIFF_W   = 33;
    localparam int MAG_W    = 17;
    localparam logic [MAG_W-1:0] MAG_CLAMP = 17'h10000;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int LIM_SQ_W = 2 * CFG_W;

endpackage

// ----- rtl/core/wdf_dist.sv -----
// Two-stage squared-distance unit: clamped magnitudes, then squares.
module wdf_dist #(
    parameter int COORD_BITS = wdf_pkg::DEF_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_ld_mag,
    input  logic                              i_ld_sq,
    input  logic signed [COORD_BITS-1:0]      i_a_x,
    input  logic signed [COORD_BITS-1:0]      i_a_y,
    input  logic signed [COORD_BITS-1:0]      i_b_x,
    input  logic signed [COORD_BITS-1:0]      i_b_y,
    input  logic [wdf_pkg::CFG_W-1:0]         i_limit,
    output logic [wdf_pkg::SUM_W-1:0]         o_sum_sq,
    output logic [wdf_pkg::LIM_SQ_W-1:0]      o_lim_sq
);
    import wdf_pkg::*;

    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic [DIFF_W-1:0]        w_abs_x;
    logic [DIFF_W-1:0]        w_abs_y;
    logic [MAG_W-1:0]         w_mag_x;
    logic [MAG_W-1:0]         w_mag_y;

    logic [MAG_W-1:0]    r_mag_x;
    logic [MAG_W-1:0]    r_mag_y;
    logic [CFG_W-1:0]    r_lim;
    logic [SQ_W-1:0]     r_sq_x;
    logic [SQ_W-1:0]     r_sq_y;
    logic [LIM_SQ_W-1:0] r_lim_sq;

    assign w_dx = DIFF_W'(i_a_x) - DIFF_W'(i_b_x);
    assign w_dy = DIFF_W'(i_a_y) - DIFF_W'(i_b_y);
    assign w_abs_x = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
    assign w_abs_y = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);

    // Both limits stay below 65536, so clamping leaves every compare intact.
    assign w_mag_x = (w_abs_x > DIFF_W'(MAG_CLAMP)) ? MAG_CLAMP : w_abs_x[MAG_W-1:0];
    assign w_mag_y = (w_abs_y > DIFF_W'(MAG_CLAMP)) ? MAG_CLAMP : w_abs_y[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ld_mag) begin
            r_mag_x <= w_mag_x;
            r_mag_y <= w_mag_y;
            r_lim   <= i_limit;
        end
        if (i_ld_sq) begin
            r_sq_x   <= SQ_W'(r_mag_x) * SQ_W'(r_mag_x);
            r_sq_y   <= SQ_W'(r_mag_y) * SQ_W'(r_mag_y);
            r_lim_sq <= LIM_SQ_W'(r_lim) * LIM_SQ_W'(r_lim);
        end
    end

    assign o_sum_sq = SUM_W'(r_sq_x) + SUM_W'(r_sq_y);
    assign o_lim_sq = r_lim_sq;

endmodule

// ----- rtl/core/wdf_store.sv -----
// Waypoint store: one write port and one registered read port.
module wdf_store #(
    parameter int MAX_WAYPOINTS = wdf_pkg::DEF_MAX_WAYPOINTS,
    parameter int COORD_BITS    = wdf_pkg::DEF_COORD_BITS,
    localparam int IDX_W        = $clog2(MAX_WAYPOINTS)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [IDX_W-1:0]             i_wr_addr,
    input  logic signed [COORD_BITS-1:0] i_wr_x,
    input  logic signed [COORD_BITS-1:0] i_wr_y,
    input  logic [IDX_W-1:0]             i_rd_addr,
    output logic signed [COORD_BITS-1:0] o_rd_x,
    output logic signed [COORD_BITS-1:0] o_rd_y
);
    import wdf_pkg::*;

    logic [2*COORD_BITS-1:0] r_mem [MAX_WAYPOINTS];
    logic [2*COORD_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_x = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign o_rd_y = r_rd[COORD_BITS-1:0];

endmodule

// ----- rtl/core/waypoint_decimate_and_follow_core.sv -----
// A result word is loaded into the output register after the magnitude, square and update
// steps; a final path point that is also far enough to be kept adds a deferred write step,
// since both copies go through the store's single write port. A new input word is only
// accepted in the idle state, so the next word waits until the last result is loaded, and
// the update waits while the output register holds a word not yet taken. Reset (synchronous,
// active low) clears all control state and loads the default thresholds; the store is not cleared.
`include "waypoint_decimate_and_follow_core_macros.svh"

module waypoint_decimate_and_follow_core #(
    parameter int MAX_WAYPOINTS = wdf_pkg::DEF_MAX_WAYPOINTS,
    parameter int COORD_BITS    = wdf_pkg::DEF_COORD_BITS,
    localparam int IDX_W        = $clog2(MAX_WAYPOINTS),
    localparam int CNT_W        = $clog2(MAX_WAYPOINTS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [wdf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wdf_pkg::CFG_W-1:0]         i_cfg_wdata,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic signed [COORD_BITS-1:0]      i_pos_x,
    input  logic signed [COORD_BITS-1:0]      i_pos_y,
    input  logic                              i_path_first,
    input  logic                              i_path_last,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [COORD_BITS-1:0]      o_goal_x,
    output logic signed [COORD_BITS-1:0]      o_goal_y,
    output logic                              o_goal_valid,
    output logic                              o_goal_changed,
    output logic                              o_path_finished,
    output logic [IDX_W-1:0]                  o_goal_position,
    output logic [CNT_W-1:0]                  o_store_count,
    output logic                              o_store_overflow
);
    import wdf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DUP  = 2'd3;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_WAYPOINTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_WAYPOINTS - 1);

    // Control state
    logic [1:0]                   r_state, n_state;
    logic [CFG_W-1:0]             r_spacing;
    logic [CFG_W-1:0]             r_arrival;
    logic [CNT_W-1:0]             r_total, n_total;
    logic signed [COORD_BITS-1:0] r_veh_x, n_veh_x;
    logic signed [COORD_BITS-1:0] r_veh_y, n_veh_y;
    logic signed [COORD_BITS-1:0] r_ref_x, n_ref_x;
    logic signed [COORD_BITS-1:0] r_ref_y, n_ref_y;
    logic signed [COORD_BITS-1:0] r_goal_x, n_goal_x;
    logic signed [COORD_BITS-1:0] r_goal_y, n_goal_y;
    logic [IDX_W-1:0]             r_goal_idx, n_goal_idx;
    logic                         r_pending, n_pending;
    logic                         r_goal_valid, n_goal_valid;
    logic                         r_finished, n_finished;
    logic                         r_overflow, n_overflow;
    logic                         r_out_valid;

    // Captured input word and pending second write
    logic                         r_mode;
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic                         r_first;
    logic                         r_last;
    logic [IDX_W-1:0]             r_dup_addr, n_dup_addr;

    // Output register
    logic signed [COORD_BITS-1:0] r_out_goal_x;
    logic signed [COORD_BITS-1:0] r_out_goal_y;
    logic                         r_out_goal_valid;
    logic                         r_out_changed;
    logic                         r_out_finished;
    logic [IDX_W-1:0]             r_out_goal_idx;
    logic [CNT_W-1:0]             r_out_total;
    logic                         r_out_overflow;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic                         w_load_out;
    logic                         w_changed;
    logic signed [COORD_BITS-1:0] w_b_x;
    logic signed [COORD_BITS-1:0] w_b_y;
    logic [CFG_W-1:0]             w_limit;
    logic [SUM_W-1:0]             w_sum_sq;
    logic [LIM_SQ_W-1:0]          w_lim_sq;
    logic [SUM_W-1:0]             w_lim_ext;
    logic                         w_far;
    logic                         w_near;
    logic                         w_spaced;
    logic [CNT_W-1:0]             w_total_eff;
    logic [CNT_W-1:0]             w_total1;
    logic [CNT_W-1:0]             w_last_idx;
    logic [IDX_W-1:0]             w_last_addr;
    logic                         w_we;
    logic [IDX_W-1:0]             w_wr_addr;
    logic [IDX_W-1:0]             w_rd_addr;
    logic signed [COORD_BITS-1:0] w_rd_x;
    logic signed [COORD_BITS-1:0] w_rd_y;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // A path point is measured from the reference (the vehicle when it opens a
    // path); a pose measures the goal against the new vehicle position.
    always_comb begin
        if (i_mode == MODE_PATH) begin
            w_b_x   = i_path_first ? r_veh_x : r_ref_x;
            w_b_y   = i_path_first ? r_veh_y : r_ref_y;
            w_limit = r_spacing;
        end else begin
            w_b_x   = r_goal_x;
            w_b_y   = r_goal_y;
            w_limit = r_arrival;
        end
    end

    wdf_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_ld_mag (w_in_acc),
        .i_ld_sq  (r_state == S_SQ),
        .i_a_x    (i_pos_x),
        .i_a_y    (i_pos_y),
        .i_b_x    (w_b_x),
        .i_b_y    (w_b_y),
        .i_limit  (w_limit),
        .o_sum_sq (w_sum_sq),
        .o_lim_sq (w_lim_sq)
    );

    // The goal read address depends only on state that holds from acceptance
    // to the update, and any store write lands before the word is accepted, so
    // the registered read data is current when the update uses it.
    assign w_rd_addr = r_pending ? '0 : r_goal_idx + IDX_W'(1);

    wdf_store #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .COORD_BITS    (COORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_x    (r_px),
        .i_wr_y    (r_py),
        .i_rd_addr (w_rd_addr),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y)
    );

    assign w_lim_ext   = SUM_W'(w_lim_sq);
    assign w_far       = w_sum_sq > w_lim_ext;
    assign w_near      = w_sum_sq < w_lim_ext;
    assign w_total_eff = r_first ? '0 : r_total;
    assign w_spaced    = w_far && (w_total_eff < (MAX_CNT - CNT_W'(1)));
    assign w_total1    = w_spaced ? (w_total_eff + CNT_W'(1)) : w_total_eff;
    assign w_last_addr = (w_total1 < MAX_CNT) ? w_total1[IDX_W-1:0] : LAST_SLOT;
    assign w_last_idx  = r_total - CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_veh_x      = r_veh_x;
        n_veh_y      = r_veh_y;
        n_ref_x      = r_ref_x;
        n_ref_y      = r_ref_y;
        n_goal_x     = r_goal_x;
        n_goal_y     = r_goal_y;
        n_goal_idx   = r_goal_idx;
        n_pending    = r_pending;
        n_goal_valid = r_goal_valid;
        n_finished   = r_finished;
        n_overflow   = r_overflow;
        n_dup_addr   = r_dup_addr;
        w_we         = 1'b0;
        w_wr_addr    = w_last_addr;
        w_load_out   = 1'b0;
        w_changed    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_state    = S_IDLE;
                    w_load_out = 1'b1;
                    if (r_mode == MODE_PATH) begin
                        n_overflow = r_first ? 1'b0 : r_overflow;
                        n_finished = r_first ? 1'b0 : r_finished;
                        n_pending  = r_pending || r_first;
                        n_ref_x    = r_first ? r_veh_x : r_ref_x;
                        n_ref_y    = r_first ? r_veh_y : r_ref_y;
                        n_total    = w_total1;
                        if (w_spaced) begin
                            w_we      = 1'b1;
                            w_wr_addr = w_total_eff[IDX_W-1:0];
                            n_ref_x   = r_px;
                            n_ref_y   = r_py;
                        end else if (w_far) begin
                            n_overflow = 1'b1;
                        end
                        if (r_last) begin
                            if (w_total1 < MAX_CNT) begin
                                n_total = w_total1 + CNT_W'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                            if (w_spaced) begin
                                // Second copy of the point needs its own write cycle.
                                n_dup_addr = w_last_addr;
                                n_state    = S_DUP;
                                w_load_out = 1'b0;
                            end else begin
                                w_we = 1'b1;
                            end
                        end
                    end else begin
                        n_veh_x = r_px;
                        n_veh_y = r_py;
                        if (r_total != '0) begin
                            if (r_pending) begin
                                n_goal_x     = w_rd_x;
                                n_goal_y     = w_rd_y;
                                n_goal_idx   = '0;
                                n_goal_valid = 1'b1;
                                n_pending    = 1'b0;
                                w_changed    = 1'b1;
                            end else if (w_near && (CNT_W'(r_goal_idx) < w_last_idx)) begin
                                n_goal_x     = w_rd_x;
                                n_goal_y     = w_rd_y;
                                n_goal_idx   = r_goal_idx + IDX_W'(1);
                                n_goal_valid = 1'b1;
                                w_changed    = 1'b1;
                            end else if (CNT_W'(r_goal_idx) == w_last_idx) begin
                                n_finished = 1'b1;
                            end
                        end
                    end
                end
            end
            S_DUP: begin
                if (w_out_free) begin
                    w_we       = 1'b1;
                    w_wr_addr  = r_dup_addr;
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_spacing    <= RST_SPACING;
            r_arrival    <= RST_ARRIVAL;
            r_total      <= '0;
            r_veh_x      <= '0;
            r_veh_y      <= '0;
            r_ref_x      <= '0;
            r_ref_y      <= '0;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_goal_idx   <= '0;
            r_pending    <= 1'b0;
            r_goal_valid <= 1'b0;
            r_finished   <= 1'b0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_veh_x      <= n_veh_x;
            r_veh_y      <= n_veh_y;
            r_ref_x      <= n_ref_x;
            r_ref_y      <= n_ref_y;
            r_goal_x     <= n_goal_x;
            r_goal_y     <= n_goal_y;
            r_goal_idx   <= n_goal_idx;
            r_pending    <= n_pending;
            r_goal_valid <= n_goal_valid;
            r_finished   <= n_finished;
            r_overflow   <= n_overflow;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SPACING: r_spacing <= i_cfg_wdata;
                    REG_ARRIVAL: r_arrival <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_mode;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_first <= i_path_first;
            r_last  <= i_path_last;
        end
        r_dup_addr <= n_dup_addr;
        if (w_load_out) begin
            r_out_goal_x     <= n_goal_x;
            r_out_goal_y     <= n_goal_y;
            r_out_goal_valid <= n_goal_valid;
            r_out_changed    <= w_changed;
            r_out_finished   <= n_finished;
            r_out_goal_idx   <= n_goal_idx;
            r_out_total      <= n_total;
            r_out_overflow   <= n_overflow;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_goal_x         = r_out_goal_x;
    assign o_goal_y         = r_out_goal_y;
    assign o_goal_valid     = r_out_goal_valid;
    assign o_goal_changed   = r_out_changed;
    assign o_path_finished  = r_out_finished;
    assign o_goal_position  = r_out_goal_idx;
    assign o_store_count    = r_out_total;
    assign o_store_overflow = r_out_overflow;

    // Once a goal is settled it always points at a stored entry.
    `WDF_ASSERT_IMPLY(a_goal_in_store, i_clk, i_rst_n, r_goal_valid && !r_pending, CNT_W'(r_goal_idx) < r_total, "goal index beyond stored waypoints")

    // Finished can only be reached with a non-empty store.
    `WDF_ASSERT_IMPLY(a_finished_nonempty, i_clk, i_rst_n, r_finished, r_total != '0, "finished set with an empty store")

    // The deferred copy of a final point always lands in the last occupied slot.
    `WDF_ASSERT_IMPLY(a_dup_slot, i_clk, i_rst_n, r_state == S_DUP, CNT_W'(r_dup_addr) == (r_total - CNT_W'(1)), "deferred write slot mismatch")

endmodule

// ----- sim/waypoint_goal_monitor.sv -----
// Channel monitor for the waypoint follower: predicts every result word and compares it.
module waypoint_goal_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wdf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wdf_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_mode,
    input  logic signed [wdf_pkg::DEF_COORD_BITS-1:0] i_pos_x,
    input  logic signed [wdf_pkg::DEF_COORD_BITS-1:0] i_pos_y,
    input  logic                            i_path_first,
    input  logic                            i_path_last,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [wdf_pkg::DEF_COORD_BITS-1:0] i_goal_x,
    input  logic [wdf_pkg::DEF_COORD_BITS-1:0] i_goal_y,
    input  logic                            i_goal_valid,
    input  logic                            i_goal_changed,
    input  logic                            i_path_finished,
    input  logic [$clog2(wdf_pkg::DEF_MAX_WAYPOINTS)-1:0]   i_goal_position,
    input  logic [$clog2(wdf_pkg::DEF_MAX_WAYPOINTS+1)-1:0] i_store_count,
    input  logic                            i_store_overflow,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import wdf_pkg::*;

    localparam int NWP = DEF_MAX_WAYPOINTS;
    localparam int CW  = DEF_COORD_BITS;
    localparam int IW  = $clog2(NWP);
    localparam int NW  = $clog2(NWP + 1);
    localparam longint MAG_LIMIT = 65536;

    typedef struct packed {
        logic [CW-1:0] goal_x;
        logic [CW-1:0] goal_y;
        logic          goal_valid;
        logic          goal_changed;
        logic          path_finished;
        logic [IW-1:0] goal_position;
        logic [NW-1:0] store_count;
        logic          store_overflow;
    } t_goal_word;

    logic [CFG_W-1:0]     spacing_mm;
    logic [CFG_W-1:0]     arrival_mm;
    logic signed [CW-1:0] wp_x [NWP];
    logic signed [CW-1:0] wp_y [NWP];
    int unsigned          wp_count;
    logic signed [CW-1:0] veh_x, veh_y;
    logic signed [CW-1:0] ref_x, ref_y;
    logic signed [CW-1:0] goal_x, goal_y;
    int unsigned          goal_idx;
    bit                   restart_pending, goal_ok, done, dropped;
    t_goal_word           goal_words_due[$];
    int                   word_faults;

    // Squared distance with each component clamped, as the hardware compares it.
    function automatic longint sq_span(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                       logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
        longint dx, dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > MAG_LIMIT) dx = MAG_LIMIT;
        if (dy > MAG_LIMIT) dy = MAG_LIMIT;
        return dx * dx + dy * dy;
    endfunction

    function automatic t_goal_word follow_step(logic mode, logic signed [CW-1:0] px,
                                               logic signed [CW-1:0] py, logic first,
                                               logic last);
        t_goal_word  w;
        bit          changed;
        int unsigned tail;
        longint      limit_sq;
        changed = 1'b0;
        if (mode == MODE_PATH) begin
            limit_sq = longint'(spacing_mm) * longint'(spacing_mm);
            if (first) begin
                wp_count = 0;
                ref_x = veh_x;
                ref_y = veh_y;
                dropped = 1'b0;
                done = 1'b0;
                restart_pending = 1'b1;
            end
            if (sq_span(px, py, ref_x, ref_y) > limit_sq) begin
                if (wp_count < NWP - 1) begin
                    wp_x[wp_count] = px;
                    wp_y[wp_count] = py;
                    wp_count++;
                    ref_x = px;
                    ref_y = py;
                end else begin
                    dropped = 1'b1;
                end
            end
            // The final point always lands; on a full store it replaces the top slot.
            if (last) begin
                if (wp_count < NWP) begin
                    wp_x[wp_count] = px;
                    wp_y[wp_count] = py;
                    wp_count++;
                end else begin
                    wp_x[NWP-1] = px;
                    wp_y[NWP-1] = py;
                    dropped = 1'b1;
                end
            end
        end else begin
            limit_sq = longint'(arrival_mm) * longint'(arrival_mm);
            veh_x = px;
            veh_y = py;
            if (wp_count != 0) begin
                tail = wp_count - 1;
                if (restart_pending ||
                    (sq_span(goal_x, goal_y, veh_x, veh_y) < limit_sq && goal_idx < tail)) begin
                    goal_idx = restart_pending ? 0 : goal_idx + 1;
                    restart_pending = 1'b0;
                    goal_x = wp_x[goal_idx];
                    goal_y = wp_y[goal_idx];
                    goal_ok = 1'b1;
                    changed = 1'b1;
                end else if (goal_idx == tail) begin
                    done = 1'b1;
                end
            end
        end
        w.goal_x = goal_x;
        w.goal_y = goal_y;
        w.goal_valid = goal_ok;
        w.goal_changed = changed;
        w.path_finished = done;
        w.goal_position = IW'(goal_idx);
        w.store_count = NW'(wp_count);
        w.store_overflow = dropped;
        return w;
    endfunction

    function automatic string word_text(t_goal_word w);
        return $sformatf({"goal (%0d,%0d) valid %0b changed %0b finished %0b",
                          " index %0d count %0d ovf %0b"},
                         $signed(w.goal_x), $signed(w.goal_y), w.goal_valid, w.goal_changed,
                         w.path_finished, w.goal_position, w.store_count, w.store_overflow);
    endfunction

    always @(posedge i_clk) begin
        t_goal_word seen;
        t_goal_word due;
        if (!i_rst_n) begin
            spacing_mm = RST_SPACING;
            arrival_mm = RST_ARRIVAL;
            wp_count = 0;
            veh_x = '0;
            veh_y = '0;
            ref_x = '0;
            ref_y = '0;
            goal_x = '0;
            goal_y = '0;
            goal_idx = 0;
            restart_pending = 1'b0;
            goal_ok = 1'b0;
            done = 1'b0;
            dropped = 1'b0;
            goal_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SPACING) spacing_mm = i_cfg_wdata;
                else if (i_cfg_idx == REG_ARRIVAL) arrival_mm = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                due = follow_step(i_mode, i_pos_x, i_pos_y, i_path_first, i_path_last);
                goal_words_due = {goal_words_due, due};
            end
            if (i_out_valid && i_out_ready) begin
                seen = {i_goal_x, i_goal_y, i_goal_valid, i_goal_changed, i_path_finished,
                        i_goal_position, i_store_count, i_store_overflow};
                if (goal_words_due.size() == 0) begin
                    word_faults++;
                    if (word_faults <= 10)
                        $display("%0t: result word with nothing pending: %s", $realtime,
                                 word_text(seen));
                end else begin
                    due = goal_words_due.pop_front();
                    if (seen != due) begin
                        word_faults++;
                        if (word_faults <= 10) begin
                            $display("%0t: result word mismatch", $realtime);
                            $display("    expected %s", word_text(due));
                            $display("    actual   %s", word_text(seen));
                        end
                    end
                end
            end
        end
        o_outstanding = goal_words_due.size();
        o_fail_count = word_faults;
    end

endmodule

// ----- sim/waypoint_decimate_and_follow_core_tb.sv -----
// Stimulus and verdict for the waypoint decimate-and-follow core.
module waypoint_decimate_and_follow_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wdf_pkg::*;

    localparam int CW          = DEF_COORD_BITS;
    localparam int IW          = $clog2(DEF_MAX_WAYPOINTS);
    localparam int NW          = $clog2(DEF_MAX_WAYPOINTS + 1);
    localparam int COORD_MIN   = -(1 << (CW - 1));
    localparam int COORD_MAX   = (1 << (CW - 1)) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  in_mode = MODE_POSE;
    logic signed [CW-1:0]  in_x = '0;
    logic signed [CW-1:0]  in_y = '0;
    logic                  in_first = 1'b0;
    logic                  in_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [CW-1:0]  goal_x, goal_y;
    logic                  goal_valid, goal_changed, path_finished, store_overflow;
    logic [IW-1:0]         goal_position;
    logic [NW-1:0]         store_count;

    int  fail_count;
    int  outstanding;
    int  words_sent;
    bit  send_calm, recv_calm, hold_req;
    int  veh_x, veh_y;
    int  route_x[$], route_y[$];
    int  aim;

    waypoint_decimate_and_follow_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_pos_x         (in_x),
        .i_pos_y         (in_y),
        .i_path_first    (in_first),
        .i_path_last     (in_last),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_goal_x        (goal_x),
        .o_goal_y        (goal_y),
        .o_goal_valid    (goal_valid),
        .o_goal_changed  (goal_changed),
        .o_path_finished (path_finished),
        .o_goal_position (goal_position),
        .o_store_count   (store_count),
        .o_store_overflow(store_overflow)
    );

    waypoint_goal_monitor watch (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_pos_x         (in_x),
        .i_pos_y         (in_y),
        .i_path_first    (in_first),
        .i_path_last     (in_last),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_goal_x        (goal_x),
        .i_goal_y        (goal_y),
        .i_goal_valid    (goal_valid),
        .i_goal_changed  (goal_changed),
        .i_path_finished (path_finished),
        .i_goal_position (goal_position),
        .i_store_count   (store_count),
        .i_store_overflow(store_overflow),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int jitter(int c, int span);
        int v;
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < COORD_MIN) v = COORD_MIN;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    // Valid stays high into the next call, which either lowers it or offers the next word.
    task automatic send_word(logic mode, int x, int y, logic first, logic last);
        int gap;
        if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_mode = mode;
        in_x = CW'(x);
        in_y = CW'(y);
        in_first = first;
        in_last = last;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_point(bit first, bit last, int x, int y);
        if (first) begin
            route_x.delete();
            route_y.delete();
            aim = 0;
        end
        route_x = {route_x, x};
        route_y = {route_y, y};
        send_word(MODE_PATH, x, y, first, last);
    endtask

    task automatic send_pose(int x, int y);
        veh_x = x;
        veh_y = y;
        send_word(MODE_POSE, x, y, coin(), coin());
    endtask

    // Mostly walk the vehicle along the points of the current path so goals advance.
    task automatic follow_pose();
        if (route_x.size() != 0 && $urandom_range(0, 3) != 0) begin
            send_pose(jitter(route_x[aim], 300), jitter(route_y[aim], 300));
            if ($urandom_range(0, 2) != 0 && aim < route_x.size() - 1) aim++;
        end else begin
            send_pose(jitter(veh_x, 5000), jitter(veh_y, 5000));
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        drain();
        cfg_idx = idx;
        cfg_wdata = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic directed();
        send_word(MODE_POSE, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
        send_pose(0, 0);
        send_point(1'b1, 1'b1, 0, 0);
        send_pose(0, 0);
        send_pose(0, 0);
        send_point(1'b1, 1'b0, 1000, 0);
        send_point(1'b0, 1'b0, 2500, 0);
        send_pose(2500, 100);
        send_point(1'b0, 1'b0, 2500, 2000);
        send_point(1'b0, 1'b0, COORD_MIN, COORD_MAX);
        send_point(1'b0, 1'b1, COORD_MIN, COORD_MAX);
        send_pose(2600, 0);
        send_pose(COORD_MIN, COORD_MAX);
        send_pose(COORD_MIN + 100, COORD_MAX);
        send_point(1'b0, 1'b0, COORD_MAX, COORD_MIN);
        send_pose(COORD_MAX, COORD_MIN);
        send_point(1'b1, 1'b1, COORD_MAX, COORD_MAX);
        send_pose(COORD_MAX, COORD_MAX);
        send_pose(COORD_MAX, COORD_MAX);
        send_pose(COORD_MAX - 200, COORD_MAX);
    endtask

    task automatic run_mix(int n);
        int stop, len, kind, px, py;
        stop = words_sent + n;
        while (words_sent < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                len = $urandom_range(1, 12);
                px = jitter(veh_x, 3000);
                py = jitter(veh_y, 3000);
                for (int k = 0; k < len; k++) begin
                    send_point(k == 0, k == len - 1, px, py);
                    px = jitter(px, 3000);
                    py = jitter(py, 3000);
                    if ($urandom_range(0, 9) == 0) follow_pose();
                end
                repeat ($urandom_range(3, 16)) follow_pose();
            end else if (kind < 78) begin
                // Points appended to whatever the store already holds.
                repeat ($urandom_range(1, 4))
                    send_point(1'b0, coin(), jitter(veh_x, 4000), jitter(veh_y, 4000));
            end else if (kind < 86) begin
                repeat ($urandom_range(1, 4))
                    send_point(coin(), coin(), any_coord(), any_coord());
            end else if (kind < 94) begin
                repeat ($urandom_range(1, 4)) send_pose(any_coord(), any_coord());
            end else begin
                // A path that never receives its final point.
                send_point(1'b1, 1'b0, jitter(veh_x, 3000), jitter(veh_y, 3000));
                repeat ($urandom_range(0, 5))
                    send_point(1'b0, 1'b0, jitter(veh_x, 6000), jitter(veh_y, 6000));
                repeat ($urandom_range(1, 6)) follow_pose();
            end
        end
    endtask

    // With zero spacing every distinct point is kept, so one long path fills the store.
    task automatic fill_store();
        int px, py;
        set_reg(REG_SPACING, '0);
        set_reg(REG_ARRIVAL, RST_ARRIVAL);
        px = jitter(veh_x, 400);
        py = jitter(veh_y, 400);
        for (int k = 0; k < DEF_MAX_WAYPOINTS + 6; k++) begin
            send_point(k == 0, 1'b0, px, py);
            px = jitter(px, 400);
            py = jitter(py, 400);
            if (k % 128 == 0) follow_pose();
        end
        send_point(1'b0, 1'b1, px, py);
        send_point(1'b0, 1'b1, jitter(px, 400), jitter(py, 400));
        send_point(1'b0, 1'b1, any_coord(), any_coord());
        repeat (8) follow_pose();
    endtask

    // Receiver: random stalls before each result word, one long hold on request.
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) recv_calm = !recv_calm;
            stall = recv_calm ? 0 : $urandom_range(0, 18);
            if (hold_req) begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall != 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        directed();
        set_reg(REG_SPACING, '0);
        set_reg(REG_ARRIVAL, '1);
        run_mix(50);
        set_reg(REG_SPACING, '1);
        set_reg(REG_ARRIVAL, '0);
        run_mix(40);
        fill_store();
        set_reg(REG_SPACING, RST_SPACING);
        set_reg(REG_ARRIVAL, RST_ARRIVAL);
        hold_req = 1'b1;
        run_mix(30);
        drain();
        run_mix(30);
        repeat (4) begin
            set_reg(REG_SPACING, CFG_W'($urandom_range(0, 4000)));
            set_reg(REG_ARRIVAL, CFG_W'($urandom_range(0, 1500)));
            run_mix(12);
        end
        set_reg(REG_SPACING, CFG_W'($urandom_range(0, 65535)));
        set_reg(REG_ARRIVAL, CFG_W'($urandom_range(0, 65535)));
        run_mix(15);
        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
